>>> hw/rtl/vp9_frame_header_peek_top_defines.svh
// Assertion macros for the VP9 frame header peek block.
// Included by the top level; needs a clock named i_clk and reset i_rst_n in scope.
`ifndef VP9_FRAME_HEADER_PEEK_TOP_DEFINES_SVH
`define VP9_FRAME_HEADER_PEEK_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define VFHP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define VFHP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/vp9fhp_pkg.sv
// Types, constants and the per-bit parse step of the VP9 frame header peek.
// No dependencies; used by vp9_frame_header_peek_top.
package vp9fhp_pkg;

    // Parse phases (plain state codes)
    localparam logic [3:0] PH_MARKER     = 4'd0;
    localparam logic [3:0] PH_PROFILE    = 4'd1;
    localparam logic [3:0] PH_SHOW_EXIST = 4'd2;
    localparam logic [3:0] PH_SLOT       = 4'd3;
    localparam logic [3:0] PH_FRAME_TYPE = 4'd4;
    localparam logic [3:0] PH_SHOWN      = 4'd5;
    localparam logic [3:0] PH_ERR_RES    = 4'd6;
    localparam logic [3:0] PH_INTRA_ONLY = 4'd7;
    localparam logic [3:0] PH_RESET_CTX  = 4'd8;
    localparam logic [3:0] PH_SYNC       = 4'd9;
    localparam logic [3:0] PH_CC_DEPTH   = 4'd10;
    localparam logic [3:0] PH_CC_SPACE   = 4'd11;
    localparam logic [3:0] PH_CC_RANGE   = 4'd12;
    localparam logic [3:0] PH_REFRESH    = 4'd13;
    localparam logic [3:0] PH_DONE       = 4'd14;

    // Header flag bit positions
    localparam int FL_KEY   = 0;
    localparam int FL_SHOW  = 1;
    localparam int FL_ERR   = 2;
    localparam int FL_INTRA = 3;

    // Field values
    localparam logic [23:0] MARKER_CODE = 24'h000002;
    localparam logic [23:0] SYNC_CODE   = 24'h498342;
    localparam logic [7:0]  KEY_REFRESH = 8'hff;
    localparam logic [2:0]  RGB_SPACE   = 3'd7;
    localparam logic [1:0]  PROFILE_0   = 2'd0;
    localparam logic [1:0]  PROFILE_2   = 2'd2;

    typedef struct packed {
        logic [3:0]  phase;
        logic [4:0]  cnt;
        logic [23:0] accum;
        logic [3:0]  flags;
        logic        done;
    } t_parse_state;

    typedef struct packed {
        logic       valid;
        logic       status;
        logic       show_existing;
        logic       shown;
        logic [2:0] map_slot;
        logic [7:0] refresh_mask;
    } t_result;

    typedef struct packed {
        t_parse_state st;
        t_result      res;
    } t_step;

    localparam t_parse_state ST_REARM = '{
        phase: PH_MARKER, cnt: 5'd0, accum: 24'd0, flags: 4'd0, done: 1'b0
    };

    localparam t_result RES_FAIL = '{
        valid: 1'b1, status: 1'b1, show_existing: 1'b0, shown: 1'b0,
        map_slot: 3'd0, refresh_mask: 8'd0
    };

    // Bits in each header field
    function automatic logic [4:0] phase_len(logic [3:0] ph);
        logic [4:0] len;
        case (ph)
            PH_MARKER, PH_PROFILE, PH_RESET_CTX: len = 5'd2;
            PH_SLOT, PH_CC_SPACE:                len = 5'd3;
            PH_SYNC:                             len = 5'd24;
            PH_REFRESH:                          len = 5'd8;
            default:                             len = 5'd1;
        endcase
        return len;
    endfunction

    // Phase after the reset-context bits of a non-key frame
    function automatic logic [3:0] after_reset(logic [3:0] flags);
        return flags[FL_INTRA] ? PH_SYNC : PH_REFRESH;
    endfunction

    // Consume one header bit
    function automatic t_step feed_bit(t_parse_state s, logic b, logic [1:0] prof);
        t_step      r;
        logic [23:0] v;
        logic [1:0]  p;
        r.st       = s;
        r.res      = '0;
        r.st.accum = {s.accum[22:0], b};
        r.st.cnt   = s.cnt + 5'd1;
        v          = r.st.accum;
        p          = {v[0], v[1]};
        if (r.st.cnt >= phase_len(s.phase)) begin
            r.st.accum = '0;
            r.st.cnt   = '0;
            case (s.phase)
                PH_MARKER: begin
                    if (v != MARKER_CODE) r.res = RES_FAIL;
                    else r.st.phase = PH_PROFILE;
                end
                PH_PROFILE: begin
                    if (p != prof) r.res = RES_FAIL;
                    else r.st.phase = PH_SHOW_EXIST;
                end
                PH_SHOW_EXIST: begin
                    r.st.phase = v[0] ? PH_SLOT : PH_FRAME_TYPE;
                end
                PH_SLOT: begin
                    r.res.valid         = 1'b1;
                    r.res.show_existing = 1'b1;
                    r.res.shown         = 1'b1;
                    r.res.map_slot      = v[2:0];
                end
                PH_FRAME_TYPE: begin
                    if (!v[0]) r.st.flags[FL_KEY] = 1'b1;
                    r.st.phase = PH_SHOWN;
                end
                PH_SHOWN: begin
                    if (v[0]) r.st.flags[FL_SHOW] = 1'b1;
                    r.st.phase = PH_ERR_RES;
                end
                PH_ERR_RES: begin
                    if (v[0]) r.st.flags[FL_ERR] = 1'b1;
                    if (r.st.flags[FL_KEY])        r.st.phase = PH_SYNC;
                    else if (!r.st.flags[FL_SHOW]) r.st.phase = PH_INTRA_ONLY;
                    else if (!r.st.flags[FL_ERR])  r.st.phase = PH_RESET_CTX;
                    else                           r.st.phase = PH_REFRESH;
                end
                PH_INTRA_ONLY: begin
                    if (v[0]) r.st.flags[FL_INTRA] = 1'b1;
                    r.st.phase = r.st.flags[FL_ERR] ? after_reset(r.st.flags)
                                                    : PH_RESET_CTX;
                end
                PH_RESET_CTX: begin
                    r.st.phase = after_reset(r.st.flags);
                end
                PH_SYNC: begin
                    if (v != SYNC_CODE) begin
                        r.res = RES_FAIL;
                    end else if (prof == PROFILE_2) begin
                        r.st.phase = PH_CC_DEPTH;
                    end else if (r.st.flags[FL_KEY]) begin
                        r.res.valid        = 1'b1;
                        r.res.shown        = r.st.flags[FL_SHOW];
                        r.res.refresh_mask = KEY_REFRESH;
                    end else begin
                        r.st.phase = PH_REFRESH;
                    end
                end
                PH_CC_DEPTH: begin
                    if (v[0]) r.res = RES_FAIL;
                    else r.st.phase = PH_CC_SPACE;
                end
                PH_CC_SPACE: begin
                    if (v[2:0] == RGB_SPACE) r.res = RES_FAIL;
                    else r.st.phase = PH_CC_RANGE;
                end
                PH_CC_RANGE: begin
                    if (r.st.flags[FL_KEY]) begin
                        r.res.valid        = 1'b1;
                        r.res.shown        = r.st.flags[FL_SHOW];
                        r.res.refresh_mask = KEY_REFRESH;
                    end else begin
                        r.st.phase = PH_REFRESH;
                    end
                end
                PH_REFRESH: begin
                    r.res.valid        = 1'b1;
                    r.res.shown        = r.st.flags[FL_SHOW];
                    r.res.refresh_mask = v[7:0];
                end
                default: begin
                end
            endcase
            // A result ends the parse for this frame
            if (r.res.valid) begin
                r.st.phase = PH_DONE;
                r.st.done  = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/vp9_frame_header_peek_top.sv
// Each accepted byte is parsed from the input register; its result is registered.
// Throughput: one byte per cycle while not stalled; the eight bits are parsed together.
// A stalled result holds the parse stage, which then holds the input register.
// Reset (synchronous, i_rst_n low): parser rearmed at the frame marker, profile 0,
// both register stages empty.
// Top level of the VP9 frame header peek; uses vp9fhp_pkg and the assertion macro header.
module vp9_frame_header_peek_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_header_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_status,
    output logic       o_show_existing,
    output logic       o_shown,
    output logic [2:0] o_map_slot,
    output logic [7:0] o_refresh_mask
);

`include "vp9_frame_header_peek_top_defines.svh"

    logic [1:0]             r_profile;
    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_last;
    vp9fhp_pkg::t_parse_state r_st;
    vp9fhp_pkg::t_parse_state n_st;
    vp9fhp_pkg::t_result      r_out;
    vp9fhp_pkg::t_result      n_out;
    logic                   parse_go;
    logic                   in_beat;

    // Parse the held byte when the result register is free or draining
    assign parse_go = r_in_valid && (!r_out.valid || !i_stall);
    assign o_stall  = r_in_valid && !parse_go;
    assign in_beat  = i_valid && !o_stall;

    // Unrolled eight-bit parse of one byte
    always_comb begin
        vp9fhp_pkg::t_step        stp;
        vp9fhp_pkg::t_parse_state s;
        vp9fhp_pkg::t_result      res;
        s   = r_st;
        res = '0;
        stp = '0;
        if (!s.done) begin
            if (!(r_profile inside {vp9fhp_pkg::PROFILE_0, vp9fhp_pkg::PROFILE_2})) begin
                res     = vp9fhp_pkg::RES_FAIL;
                s.phase = vp9fhp_pkg::PH_DONE;
                s.done  = 1'b1;
            end else begin
                for (int i = 7; i >= 0; i--) begin
                    if (!s.done) begin
                        stp = vp9fhp_pkg::feed_bit(s, r_in_byte[i], r_profile);
                        s   = stp.st;
                        if (stp.res.valid) res = stp.res;
                    end
                end
            end
        end
        // End of frame: fail if still parsing, then rearm
        if (r_in_last) begin
            if (!s.done) res = vp9fhp_pkg::RES_FAIL;
            s = vp9fhp_pkg::ST_REARM;
        end
        n_st  = parse_go ? s : r_st;
        n_out = r_out;
        if (parse_go && res.valid) n_out = res;
        else if (!i_stall)         n_out.valid = 1'b0;
    end

    // Config, input register, parse state, result register; payload has no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_profile   <= '0;
            r_in_valid  <= 1'b0;
            r_st        <= vp9fhp_pkg::ST_REARM;
            r_out.valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_profile <= i_cfg_wdata;
            if (in_beat)       r_in_valid <= 1'b1;
            else if (parse_go) r_in_valid <= 1'b0;
            r_st        <= n_st;
            r_out.valid <= n_out.valid;
        end
        if (in_beat) begin
            r_in_byte <= i_header_byte;
            r_in_last <= i_last_byte;
        end
        r_out.status        <= n_out.status;
        r_out.show_existing <= n_out.show_existing;
        r_out.shown         <= n_out.shown;
        r_out.map_slot      <= n_out.map_slot;
        r_out.refresh_mask  <= n_out.refresh_mask;
    end

    assign o_valid         = r_out.valid;
    assign o_status        = r_out.status;
    assign o_show_existing = r_out.show_existing;
    assign o_shown         = r_out.shown;
    assign o_map_slot      = r_out.map_slot;
    assign o_refresh_mask  = r_out.refresh_mask;

    // Checks
    `VFHP_ASSERT_IMP(a_fail_clean, o_valid && o_status,
        !o_show_existing && !o_shown && o_map_slot == 3'd0 && o_refresh_mask == 8'd0,
        "failure beat carries nonzero fields")
    `VFHP_ASSERT_IMP(a_exist_shape, o_valid && o_show_existing,
        o_shown && o_refresh_mask == 8'd0, "show-existing beat malformed")
    `VFHP_ASSERT_IMP(a_done_phase, r_st.done, r_st.phase == vp9fhp_pkg::PH_DONE,
        "done flag without done phase")
    `VFHP_ASSERT_NXT(a_rearm, parse_go && r_in_last,
        r_st.phase == vp9fhp_pkg::PH_MARKER && !r_st.done && r_st.flags == 4'd0,
        "parser not rearmed after last byte")

endmodule

>>> bench/vp9_frame_header_peek_top_test.sv
// Self-checking bench for vp9_frame_header_peek_top: directed beats, then random VP9 frames.
// Depends on vp9fhp_pkg for phase codes and header constants; the predictor is local.
module vp9_frame_header_peek_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BEATS = 1700;
    localparam int RUN_LIMIT_NS = 1_000_000;
    localparam int DIR_COUNT    = 23;

    typedef struct packed {
        logic       status;
        logic       show_existing;
        logic       shown;
        logic [2:0] map_slot;
        logic [7:0] refresh_mask;
    } t_hdr_result;

    // One directed beat, optionally preceded by a profile write
    typedef struct packed {
        logic        wr_cfg;
        logic [1:0]  cfg_val;
        logic [7:0]  hdr_byte;
        logic        hdr_last;
        logic        typed;
        t_hdr_result want;
    } t_hdr_row;

    localparam logic [1:0] P0 = vp9fhp_pkg::PROFILE_0;
    localparam logic [1:0] P2 = vp9fhp_pkg::PROFILE_2;

    localparam t_hdr_result HDR_NONE  = '0;
    localparam t_hdr_result HDR_FAIL  = '{1'b1, 1'b0, 1'b0, 3'd0, 8'h00};
    localparam t_hdr_result HDR_KEY   = '{1'b0, 1'b0, 1'b1, 3'd0, 8'hff};
    localparam t_hdr_result HDR_SLOT5 = '{1'b0, 1'b1, 1'b1, 3'd5, 8'h00};

    localparam t_hdr_row DIR_ROWS [DIR_COUNT] = '{
        // show-existing frame right after reset, slot 5
        '{1'b0, P0,   8'h8D, 1'b1, 1'b1, HDR_SLOT5},
        // bad frame marker, all-zero and all-one bytes
        '{1'b0, P0,   8'h00, 1'b1, 1'b1, HDR_FAIL},
        '{1'b0, P0,   8'hFF, 1'b0, 1'b1, HDR_FAIL},
        '{1'b0, P0,   8'hFF, 1'b1, 1'b0, HDR_NONE},
        // parsed profile 3 fails on the first byte
        '{1'b0, P0,   8'hB0, 1'b1, 1'b1, HDR_FAIL},
        // profile 0 key frame, then an ignored trailing beat
        '{1'b0, P0,   8'h82, 1'b0, 1'b0, HDR_NONE},
        '{1'b0, P0,   8'h49, 1'b0, 1'b0, HDR_NONE},
        '{1'b0, P0,   8'h83, 1'b0, 1'b0, HDR_NONE},
        '{1'b0, P0,   8'h42, 1'b0, 1'b1, HDR_KEY},
        '{1'b0, P0,   8'h5A, 1'b1, 1'b0, HDR_NONE},
        // inter frame cut short: out of data
        '{1'b0, P0,   8'h86, 1'b1, 1'b1, HDR_FAIL},
        // unsupported configured profiles
        '{1'b1, 2'd3, 8'h8D, 1'b1, 1'b1, HDR_FAIL},
        '{1'b1, 2'd1, 8'h8D, 1'b1, 1'b1, HDR_FAIL},
        // profile 2 key frame with color config
        '{1'b1, P2,   8'h92, 1'b0, 1'b0, HDR_NONE},
        '{1'b0, P2,   8'h49, 1'b0, 1'b0, HDR_NONE},
        '{1'b0, P2,   8'h83, 1'b0, 1'b0, HDR_NONE},
        '{1'b0, P2,   8'h42, 1'b0, 1'b0, HDR_NONE},
        '{1'b0, P2,   8'h18, 1'b1, 1'b0, HDR_NONE},
        // profile switched to 0 in the middle of a frame
        '{1'b0, P2,   8'h92, 1'b0, 1'b0, HDR_NONE},
        '{1'b1, P0,   8'h49, 1'b0, 1'b0, HDR_NONE},
        '{1'b0, P0,   8'h83, 1'b0, 1'b0, HDR_NONE},
        '{1'b0, P0,   8'h42, 1'b0, 1'b1, HDR_KEY},
        '{1'b0, P0,   8'h00, 1'b1, 1'b0, HDR_NONE}
    };

    logic       i_clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_data;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_stall;
    logic       o_stall;
    logic       o_valid;
    logic       o_status;
    logic       o_show_existing;
    logic       o_shown;
    logic [2:0] o_map_slot;
    logic [7:0] o_refresh_mask;

    vp9_frame_header_peek_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_data),
        .i_valid         (in_valid),
        .o_stall         (o_stall),
        .i_header_byte   (in_byte),
        .i_last_byte     (in_last),
        .o_valid         (o_valid),
        .i_stall         (out_stall),
        .o_status        (o_status),
        .o_show_existing (o_show_existing),
        .o_shown         (o_shown),
        .o_map_slot      (o_map_slot),
        .o_refresh_mask  (o_refresh_mask)
    );

    // Header parser state as the predictor sees it
    logic [1:0]  cur_profile;
    logic [3:0]  parse_ph;
    int          bits_in_field;
    logic [23:0] field_val;
    logic        is_key, is_shown, is_err_res, is_intra, hdr_done;
    logic        res_ready;
    t_hdr_result parsed_res;

    t_hdr_result headers_due[$];
    t_hdr_result head_res;
    int          mismatch_cnt;
    int          live_beats;
    logic        gaps_on;

    bit          hdr_bits[$];
    logic [7:0]  frame_bytes[$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

    // Receiver stall
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            out_stall <= gaps_on && ($urandom_range(99) < 35);
        end
    end

    task report_mismatch(input string what, input int got, input int want);
        $display("%0t ERROR %s: got %0h, want %0h", $time, what, got, want);
        mismatch_cnt++;
    endtask

    // Compare each delivered header result with the oldest one due
    always @(posedge i_clk) begin
        if (rst_n && o_valid && !out_stall) begin
            if (headers_due.size() == 0) begin
                report_mismatch("result with none due, status", int'(o_status), 0);
            end else begin
                head_res = headers_due.pop_front();
                if (o_status != head_res.status)
                    report_mismatch("status", int'(o_status), int'(head_res.status));
                if (o_show_existing != head_res.show_existing)
                    report_mismatch("show_existing", int'(o_show_existing),
                                    int'(head_res.show_existing));
                if (o_shown != head_res.shown)
                    report_mismatch("shown", int'(o_shown), int'(head_res.shown));
                if (o_map_slot != head_res.map_slot)
                    report_mismatch("map_slot", int'(o_map_slot), int'(head_res.map_slot));
                if (o_refresh_mask != head_res.refresh_mask)
                    report_mismatch("refresh_mask", int'(o_refresh_mask),
                                    int'(head_res.refresh_mask));
            end
        end
    end

    function automatic int field_bits(input logic [3:0] ph);
        case (ph)
            vp9fhp_pkg::PH_MARKER, vp9fhp_pkg::PH_PROFILE,
            vp9fhp_pkg::PH_RESET_CTX:                        return 2;
            vp9fhp_pkg::PH_SLOT, vp9fhp_pkg::PH_CC_SPACE:    return 3;
            vp9fhp_pkg::PH_SYNC:                             return 24;
            vp9fhp_pkg::PH_REFRESH:                          return 8;
            default:                                         return 1;
        endcase
    endfunction

    task rearm_parser();
        parse_ph      = vp9fhp_pkg::PH_MARKER;
        bits_in_field = 0;
        field_val     = '0;
        is_key        = 1'b0;
        is_shown      = 1'b0;
        is_err_res    = 1'b0;
        is_intra      = 1'b0;
        hdr_done      = 1'b0;
    endtask

    task end_hdr(input logic st, input logic se, input logic sf,
                 input logic [2:0] slot, input logic [7:0] mask);
        parsed_res = '{st, se, sf, slot, mask};
        res_ready  = 1'b1;
        hdr_done   = 1'b1;
        parse_ph   = vp9fhp_pkg::PH_DONE;
    endtask

    task fail_hdr();
        end_hdr(1'b1, 1'b0, 1'b0, 3'd0, 8'h00);
    endtask

    // One header bit through the field state machine
    task parse_bit(input logic b);
        logic [23:0] v;
        field_val = {field_val[22:0], b};
        bits_in_field++;
        if (bits_in_field == field_bits(parse_ph)) begin
            v             = field_val;
            field_val     = '0;
            bits_in_field = 0;
            case (parse_ph)
                vp9fhp_pkg::PH_MARKER: begin
                    if (v != vp9fhp_pkg::MARKER_CODE) fail_hdr();
                    else parse_ph = vp9fhp_pkg::PH_PROFILE;
                end
                vp9fhp_pkg::PH_PROFILE: begin
                    // profile low bit comes first
                    if ({v[0], v[1]} != cur_profile) fail_hdr();
                    else parse_ph = vp9fhp_pkg::PH_SHOW_EXIST;
                end
                vp9fhp_pkg::PH_SHOW_EXIST:
                    parse_ph = v[0] ? vp9fhp_pkg::PH_SLOT : vp9fhp_pkg::PH_FRAME_TYPE;
                vp9fhp_pkg::PH_SLOT: end_hdr(1'b0, 1'b1, 1'b1, v[2:0], 8'h00);
                vp9fhp_pkg::PH_FRAME_TYPE: begin
                    is_key   = !v[0];
                    parse_ph = vp9fhp_pkg::PH_SHOWN;
                end
                vp9fhp_pkg::PH_SHOWN: begin
                    is_shown = v[0];
                    parse_ph = vp9fhp_pkg::PH_ERR_RES;
                end
                vp9fhp_pkg::PH_ERR_RES: begin
                    is_err_res = v[0];
                    if (is_key) parse_ph = vp9fhp_pkg::PH_SYNC;
                    else if (!is_shown) parse_ph = vp9fhp_pkg::PH_INTRA_ONLY;
                    else if (!is_err_res) parse_ph = vp9fhp_pkg::PH_RESET_CTX;
                    else parse_ph = vp9fhp_pkg::PH_REFRESH;
                end
                vp9fhp_pkg::PH_INTRA_ONLY: begin
                    is_intra = v[0];
                    if (!is_err_res) parse_ph = vp9fhp_pkg::PH_RESET_CTX;
                    else parse_ph = is_intra ? vp9fhp_pkg::PH_SYNC : vp9fhp_pkg::PH_REFRESH;
                end
                vp9fhp_pkg::PH_RESET_CTX:
                    parse_ph = is_intra ? vp9fhp_pkg::PH_SYNC : vp9fhp_pkg::PH_REFRESH;
                vp9fhp_pkg::PH_SYNC: begin
                    if (v != vp9fhp_pkg::SYNC_CODE) fail_hdr();
                    else if (cur_profile == P2) parse_ph = vp9fhp_pkg::PH_CC_DEPTH;
                    else if (is_key)
                        end_hdr(1'b0, 1'b0, is_shown, 3'd0, vp9fhp_pkg::KEY_REFRESH);
                    else parse_ph = vp9fhp_pkg::PH_REFRESH;
                end
                vp9fhp_pkg::PH_CC_DEPTH: begin
                    if (v[0]) fail_hdr();
                    else parse_ph = vp9fhp_pkg::PH_CC_SPACE;
                end
                vp9fhp_pkg::PH_CC_SPACE: begin
                    if (v[2:0] == vp9fhp_pkg::RGB_SPACE) fail_hdr();
                    else parse_ph = vp9fhp_pkg::PH_CC_RANGE;
                end
                vp9fhp_pkg::PH_CC_RANGE: begin
                    if (is_key)
                        end_hdr(1'b0, 1'b0, is_shown, 3'd0, vp9fhp_pkg::KEY_REFRESH);
                    else parse_ph = vp9fhp_pkg::PH_REFRESH;
                end
                vp9fhp_pkg::PH_REFRESH: end_hdr(1'b0, 1'b0, is_shown, 3'd0, v[7:0]);
                default: begin
                end
            endcase
        end
    endtask

    // Expected outcome of one accepted beat
    task predict_beat(input logic [7:0] b, input logic l);
        res_ready = 1'b0;
        if (!hdr_done) begin
            if (cur_profile != P0 && cur_profile != P2) begin
                fail_hdr();
            end else begin
                for (int k = 7; k >= 0 && !hdr_done; k--)
                    parse_bit(b[k]);
            end
        end
        if (l) begin
            if (!hdr_done) fail_hdr();
            rearm_parser();
        end
    endtask

    // Send one beat; a typed row supplies its own expected result
    task drive_beat(input logic [7:0] b, input logic l, input logic typed,
                    input t_hdr_result want);
        if (gaps_on && $urandom_range(99) < 35) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        live_beats++;
        predict_beat(b, l);
        if (typed) headers_due.push_back(want);
        else if (res_ready) headers_due.push_back(parsed_res);
    endtask

    // Let the block go idle before touching the profile register
    task settle();
        in_valid <= 1'b0;
        while (headers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task write_profile(input logic [1:0] p);
        cfg_we      <= 1'b1;
        cfg_data    <= p;
        cur_profile  = p;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [1:0] pick_profile();
        int r;
        r = $urandom_range(19);
        if (r < 9) return P0;
        if (r < 18) return P2;
        return (r == 18) ? 2'd1 : 2'd3;
    endfunction

    task put_field(input logic [23:0] val, input int n);
        for (int k = n - 1; k >= 0; k--) hdr_bits.push_back(val[k]);
    endtask

    // Mostly well-formed headers with random content, some damaged or pure noise
    task compose_frame();
        logic [1:0] prof;
        logic [7:0] b;
        logic       key, shw, err, intra;
        int         k, cut;
        frame_bytes.delete();
        hdr_bits.delete();
        if ($urandom_range(99) < 5) begin
            repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
        end else begin
            prof = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : cur_profile;
            put_field(vp9fhp_pkg::MARKER_CODE, 2);
            put_field(24'(prof[0]), 1);
            put_field(24'(prof[1]), 1);
            if ($urandom_range(4) == 0) begin
                put_field(24'd1, 1);
                put_field(24'($urandom_range(7)), 3);
            end else begin
                key   = ($urandom_range(2) == 0);
                shw   = 1'($urandom_range(1));
                err   = 1'($urandom_range(1));
                intra = 1'b0;
                put_field(24'd0, 1);
                put_field(24'(!key), 1);
                put_field(24'(shw), 1);
                put_field(24'(err), 1);
                if (!key) begin
                    if (!shw) begin
                        intra = 1'($urandom_range(1));
                        put_field(24'(intra), 1);
                    end
                    if (!err) put_field(24'($urandom_range(3)), 2);
                end
                if (key || intra) begin
                    put_field(vp9fhp_pkg::SYNC_CODE, 24);
                    if (cur_profile == P2) begin
                        put_field(24'($urandom_range(19) == 0), 1);
                        put_field(24'($urandom_range(7)), 3);
                        put_field(24'($urandom_range(1)), 1);
                    end
                end
                if (!key) put_field(24'($urandom_range(255)), 8);
            end
            // flip one header bit now and then
            if ($urandom_range(99) < 8) begin
                k = $urandom_range(hdr_bits.size() - 1);
                hdr_bits[k] = !hdr_bits[k];
            end
            while (hdr_bits.size() % 8 != 0) hdr_bits.push_back(1'($urandom_range(1)));
            for (int i = 0; i < hdr_bits.size(); i += 8) begin
                for (int j = 0; j < 8; j++) b[7 - j] = hdr_bits[i + j];
                frame_bytes.push_back(b);
            end
            repeat ($urandom_range(2)) frame_bytes.push_back(8'($urandom));
            // truncated frame runs out of data
            if ($urandom_range(99) < 8) begin
                cut = $urandom_range(1, frame_bytes.size());
                while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            end
        end
    endtask

    initial begin : stimulus
        int frame_no;
        int mid;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_byte      = '0;
        in_last      = 1'b0;
        gaps_on      = 1'b1;
        mismatch_cnt = 0;
        live_beats   = 0;
        cur_profile  = P0;
        rearm_parser();
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows
        for (int r = 0; r < DIR_COUNT; r++) begin
            if (DIR_ROWS[r].wr_cfg) begin
                settle();
                write_profile(DIR_ROWS[r].cfg_val);
            end
            drive_beat(DIR_ROWS[r].hdr_byte, DIR_ROWS[r].hdr_last,
                       DIR_ROWS[r].typed, DIR_ROWS[r].want);
        end

        // Random frames, profile changed every few dozen frames
        live_beats = 0;
        frame_no   = 0;
        while (live_beats < RANDOM_BEATS) begin
            if (frame_no % 32 == 0) begin
                settle();
                write_profile(pick_profile());
            end
            gaps_on = !(live_beats >= 700 && live_beats < 950);
            compose_frame();
            mid = ($urandom_range(49) == 0) ? $urandom_range(frame_bytes.size() - 1) : -1;
            for (int i = 0; i < frame_bytes.size(); i++) begin
                if (i == mid && i > 0) begin
                    settle();
                    write_profile(pick_profile());
                end
                drive_beat(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, HDR_NONE);
            end
            frame_no++;
        end

        in_valid <= 1'b0;
        while (headers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> vp9_frame_header_peek_top.f
+incdir+hw/rtl
hw/rtl/vp9fhp_pkg.sv
hw/rtl/vp9_frame_header_peek_top.sv
bench/vp9_frame_header_peek_top_test.sv
